[hw/rtl/tmwf_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and coefficient tables for the transverse mass window filter
package tmwf_pkg;

  localparam int PhiBitsDef = 10;
  localparam int EtBitsDef  = 16;

  localparam int MassW   = 17;
  localparam int SqW     = 2 * MassW;
  localparam int CfgIdxW = 2;

  localparam int MulW  = 32;
  localparam int ProdW = 2 * MulW;

  localparam int XW   = 31;
  localparam int YW   = 32;
  localparam int Q0W  = 30;
  localparam int TW   = 31;
  localparam int SW   = 31;
  localparam int QW   = 32;
  localparam int DivW = 8;

  // 4*m is compared on a 2^30 grid, so m on a 2^28 grid
  localparam int FracW = 28;

  localparam int NumTerms = 6;
  localparam int TermW    = 3;

  localparam logic [MulW-1:0] PiQ30  = 32'd3373259426;
  localparam logic [TW-1:0]   OneQ30 = 31'd1073741824;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_MASS   = 2'd0,
    CFG_MAX_MASS   = 2'd1,
    CFG_MAX_ENABLE = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    MUL_PI_A,
    MUL_X_X,
    MUL_X2_T,
    MUL_Y_R,
    MUL_Q0_K,
    MUL_X_T,
    MUL_S_S,
    MUL_ET_MET,
    MUL_PLO_Q,
    MUL_PHI_Q,
    MUL_MIN_MIN,
    MUL_MAX_MAX
  } mul_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_PX,
    ST_X,
    ST_PXX,
    ST_X2,
    ST_PXT,
    ST_Y,
    ST_PYR,
    ST_Q0,
    ST_PQK,
    ST_T,
    ST_PS,
    ST_S,
    ST_PSS,
    ST_Q,
    ST_PE,
    ST_E,
    ST_PLO,
    ST_MLO,
    ST_MHI,
    ST_CMIN,
    ST_CMAX,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic             ld_in;
    mul_sel_t         mul_sel;
    logic             ld_x;
    logic             ld_x2;
    logic             init_t;
    logic             ld_y;
    logic             ld_q0;
    logic             ld_t;
    logic             ld_s;
    logic             ld_q;
    logic             ld_pe;
    logic             ld_m_lo;
    logic             ld_m_hi;
    logic             chk_min;
    logic             chk_max;
    logic             ld_out;
    logic [TermW-1:0] term;
  } dp_cmd_t;

  typedef struct packed {
    logic has_cand;
    logic is_last;
  } dp_stat_t;

  // divisors of the sine series, innermost term first
  function automatic logic [DivW-1:0] term_div(input logic [TermW-1:0] idx);
    logic [DivW-1:0] d;
    case (idx)
      3'd0:    d = 8'd156;
      3'd1:    d = 8'd110;
      3'd2:    d = 8'd72;
      3'd3:    d = 8'd42;
      3'd4:    d = 8'd20;
      3'd5:    d = 8'd6;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor)
  function automatic logic [Q0W-1:0] term_recip(input logic [TermW-1:0] idx);
    logic [Q0W-1:0] r;
    case (idx)
      3'd0:    r = 30'd27531841;
      3'd1:    r = 30'd39045157;
      3'd2:    r = 30'd59652323;
      3'd3:    r = 30'd102261126;
      3'd4:    r = 30'd214748364;
      3'd5:    r = 30'd715827882;
      default: r = 30'd715827882;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/transverse_mass_window_filter.sv]
`timescale 1ns / 1ps
// top level of the transverse mass window filter
//
//  channel  signals                    transfer when
//  -------  -------------------------  ---------------------
//  input    in_valid / in_ready        both high at clk edge
//  output   out_valid / out_ready      both high at clk edge
//  config   cfg_valid / cfg_ready      both high at clk edge
//
// a candidate's time from its transfer to the next transfer is set by the
// single shared 32x32 multiplier and the six-term sine series run on it
// an empty marker skips the series; one item is in flight at a time
// reset clears the flags and loads the register defaults, no clearing pass
// a last item waits in its final cycle only while an earlier pass is untaken
module transverse_mass_window_filter #(
  parameter int PHI_BITS = tmwf_pkg::PhiBitsDef,
  parameter int ET_BITS  = tmwf_pkg::EtBitsDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ET_BITS-1:0]           cand_et,
  input  logic [PHI_BITS-1:0]          cand_phi,
  input  logic [ET_BITS-1:0]           miss_et,
  input  logic [PHI_BITS-1:0]          miss_phi,
  input  logic                         has_candidate,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         pass,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tmwf_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [tmwf_pkg::MassW-1:0]   cfg_data
);
  import tmwf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  tmwf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tmwf_dp #(
    .PHI_BITS (PHI_BITS),
    .ET_BITS  (ET_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cand_et       (cand_et),
    .cand_phi      (cand_phi),
    .miss_et       (miss_et),
    .miss_phi      (miss_phi),
    .has_candidate (has_candidate),
    .last          (last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat),
    .pass          (pass)
  );

endmodule

[hw/rtl/tmwf_ctrl.sv]
`timescale 1ns / 1ps
// sequencer for the transverse mass window filter datapath
module tmwf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tmwf_pkg::dp_stat_t stat,
  output tmwf_pkg::dp_cmd_t  cmd
);
  import tmwf_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [TermW-1:0] term;
  logic [TermW-1:0] term_next;
  logic             out_valid_next;
  logic             out_blocked;

  assign out_blocked = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      term      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      term      <= term_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    term_next  = term;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_START;
        end
      end
      ST_START: state_next = stat.has_cand ? ST_PX : ST_FIN;
      ST_PX:    state_next = ST_X;
      ST_X:     state_next = ST_PXX;
      ST_PXX:   state_next = ST_X2;
      ST_X2: begin
        state_next = ST_PXT;
        term_next  = '0;
      end
      ST_PXT:   state_next = ST_Y;
      ST_Y:     state_next = ST_PYR;
      ST_PYR:   state_next = ST_Q0;
      ST_Q0:    state_next = ST_PQK;
      ST_PQK:   state_next = ST_T;
      ST_T: begin
        term_next  = term + TermW'(1);
        state_next = (term == TermW'(NumTerms - 1)) ? ST_PS : ST_PXT;
      end
      ST_PS:    state_next = ST_S;
      ST_S:     state_next = ST_PSS;
      ST_PSS:   state_next = ST_Q;
      ST_Q:     state_next = ST_PE;
      ST_PE:    state_next = ST_E;
      ST_E:     state_next = ST_PLO;
      ST_PLO:   state_next = ST_MLO;
      ST_MLO:   state_next = ST_MHI;
      ST_MHI:   state_next = ST_CMIN;
      ST_CMIN:  state_next = ST_CMAX;
      ST_CMAX:  state_next = ST_FIN;
      ST_FIN: begin
        if (!(stat.is_last && out_blocked)) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.term = term;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.ld_in  = in_valid;
      end
      ST_PX:   cmd.mul_sel = MUL_PI_A;
      ST_X:    cmd.ld_x = 1'b1;
      ST_PXX:  cmd.mul_sel = MUL_X_X;
      ST_X2: begin
        cmd.ld_x2  = 1'b1;
        cmd.init_t = 1'b1;
      end
      ST_PXT:  cmd.mul_sel = MUL_X2_T;
      ST_Y:    cmd.ld_y = 1'b1;
      ST_PYR:  cmd.mul_sel = MUL_Y_R;
      ST_Q0:   cmd.ld_q0 = 1'b1;
      ST_PQK:  cmd.mul_sel = MUL_Q0_K;
      ST_T:    cmd.ld_t = 1'b1;
      ST_PS:   cmd.mul_sel = MUL_X_T;
      ST_S:    cmd.ld_s = 1'b1;
      ST_PSS:  cmd.mul_sel = MUL_S_S;
      ST_Q:    cmd.ld_q = 1'b1;
      ST_PE:   cmd.mul_sel = MUL_ET_MET;
      ST_E:    cmd.ld_pe = 1'b1;
      ST_PLO:  cmd.mul_sel = MUL_PLO_Q;
      ST_MLO: begin
        cmd.ld_m_lo = 1'b1;
        cmd.mul_sel = MUL_PHI_Q;
      end
      ST_MHI: begin
        cmd.ld_m_hi = 1'b1;
        cmd.mul_sel = MUL_MIN_MIN;
      end
      ST_CMIN: begin
        cmd.chk_min = 1'b1;
        cmd.mul_sel = MUL_MAX_MAX;
      end
      ST_CMAX: cmd.chk_max = 1'b1;
      ST_FIN:  cmd.ld_out = stat.is_last & ~out_blocked;
      default: cmd.ld_in = 1'b0;
    endcase
  end

  assign out_valid_next = cmd.ld_out | out_blocked;

endmodule

[hw/rtl/tmwf_dp.sv]
`timescale 1ns / 1ps
// datapath: shared multiplier, sine series, mass product, threshold flags
module tmwf_dp #(
  parameter int PHI_BITS = tmwf_pkg::PhiBitsDef,
  parameter int ET_BITS  = tmwf_pkg::EtBitsDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ET_BITS-1:0]           cand_et,
  input  logic [PHI_BITS-1:0]          cand_phi,
  input  logic [ET_BITS-1:0]           miss_et,
  input  logic [PHI_BITS-1:0]          miss_phi,
  input  logic                         has_candidate,
  input  logic                         last,
  input  logic                         cfg_we,
  input  logic [tmwf_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [tmwf_pkg::MassW-1:0]   cfg_data,
  input  tmwf_pkg::dp_cmd_t            cmd,
  output tmwf_pkg::dp_stat_t           stat,
  output logic                         pass
);
  import tmwf_pkg::*;

  localparam int PW   = 2 * ET_BITS;
  localparam int MW   = PW + QW;
  localparam int CmpW = (MW - FracW > SqW) ? MW - FracW : SqW;
  localparam logic [PHI_BITS-1:0] PhiHalf = {1'b1, {(PHI_BITS-1){1'b0}}};

  logic [ET_BITS-1:0]  et_r;
  logic [ET_BITS-1:0]  met_r;
  logic [PHI_BITS-1:0] a_r;
  logic                has_r;
  logic                last_r;
  logic [XW-1:0]       x;
  logic [YW-1:0]       x2;
  logic [TW-1:0]       t;
  logic [YW-1:0]       y;
  logic [Q0W-1:0]      q0;
  logic [SW-1:0]       s;
  logic [QW-1:0]       q;
  logic [PW-1:0]       pe;
  logic [MW-1:0]       m;
  logic [ProdW-1:0]    prod;
  logic                reached_min;
  logic                exceeded_max;
  logic [MassW-1:0]    min_mass;
  logic [MassW-1:0]    max_mass;
  logic                max_enable;

  logic [PHI_BITS-1:0] w;
  logic [PHI_BITS-1:0] a_in;
  logic [MulW-1:0]     mul_a;
  logic [MulW-1:0]     mul_b;
  logic [ProdW-1:0]    rounded;
  logic [YW-1:0]       rem;
  logic [DivW-1:0]     div_k;
  logic [TW-1:0]       quot;
  logic [CmpW-1:0]     mq;
  logic [CmpW-1:0]     sq;
  logic                mfrac;

  // folded phi difference
  assign w    = cand_phi - miss_phi;
  assign a_in = (w > PhiHalf) ? (PHI_BITS'(0) - w) : w;

  assign div_k = term_div(cmd.term);

  always_comb begin
    case (cmd.mul_sel)
      MUL_PI_A: begin
        mul_a = PiQ30;
        mul_b = MulW'(a_r);
      end
      MUL_X_X: begin
        mul_a = MulW'(x);
        mul_b = MulW'(x);
      end
      MUL_X2_T: begin
        mul_a = x2;
        mul_b = MulW'(t);
      end
      MUL_Y_R: begin
        mul_a = y;
        mul_b = MulW'(term_recip(cmd.term));
      end
      MUL_Q0_K: begin
        mul_a = MulW'(q0);
        mul_b = MulW'(div_k);
      end
      MUL_X_T: begin
        mul_a = MulW'(x);
        mul_b = MulW'(t);
      end
      MUL_S_S: begin
        mul_a = MulW'(s);
        mul_b = MulW'(s);
      end
      MUL_ET_MET: begin
        mul_a = MulW'(et_r);
        mul_b = MulW'(met_r);
      end
      MUL_PLO_Q: begin
        mul_a = MulW'(pe[ET_BITS-1:0]);
        mul_b = q;
      end
      MUL_PHI_Q: begin
        mul_a = MulW'(pe[PW-1:ET_BITS]);
        mul_b = q;
      end
      MUL_MIN_MIN: begin
        mul_a = MulW'(min_mass);
        mul_b = MulW'(min_mass);
      end
      MUL_MAX_MAX: begin
        mul_a = MulW'(max_mass);
        mul_b = MulW'(max_mass);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rounded = prod + (ProdW'(1) << (PHI_BITS - 1));

  // reciprocal quotient is low by at most one
  assign rem  = y - prod[YW-1:0];
  assign quot = TW'(q0) + TW'(rem >= YW'(div_k));

  assign mq    = CmpW'(m[MW-1:FracW]);
  assign mfrac = |m[FracW-1:0];
  assign sq    = CmpW'(prod[SqW-1:0]);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.ld_in) begin
      et_r   <= cand_et;
      met_r  <= miss_et;
      a_r    <= a_in;
      has_r  <= has_candidate;
      last_r <= last;
    end
    if (cmd.ld_x) begin
      x <= rounded[PHI_BITS+XW-1:PHI_BITS];
    end
    if (cmd.ld_x2) begin
      x2 <= prod[30+YW-1:30];
    end
    if (cmd.init_t) begin
      t <= OneQ30;
    end else if (cmd.ld_t) begin
      t <= OneQ30 - quot;
    end
    if (cmd.ld_y) begin
      y <= prod[30+YW-1:30];
    end
    if (cmd.ld_q0) begin
      q0 <= prod[32+Q0W-1:32];
    end
    if (cmd.ld_s) begin
      s <= prod[30+SW-1:30];
    end
    if (cmd.ld_q) begin
      q <= prod[30+QW-1:30];
    end
    if (cmd.ld_pe) begin
      pe <= prod[PW-1:0];
    end
    if (cmd.ld_m_lo) begin
      m <= MW'(prod[ET_BITS+QW-1:0]);
    end else if (cmd.ld_m_hi) begin
      m <= m + (MW'(prod[ET_BITS+QW-1:0]) << ET_BITS);
    end
    if (cmd.ld_out) begin
      pass <= reached_min & ~exceeded_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reached_min  <= 1'b0;
      exceeded_max <= 1'b0;
      min_mass     <= '0;
      max_mass     <= '1;
      max_enable   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_MASS:   min_mass <= cfg_data;
          CFG_MAX_MASS:   max_mass <= cfg_data;
          CFG_MAX_ENABLE: max_enable <= cfg_data[0];
          default:        max_enable <= max_enable;
        endcase
      end
      if (cmd.ld_out) begin
        reached_min  <= 1'b0;
        exceeded_max <= 1'b0;
      end else begin
        if (cmd.chk_min && mq >= sq) begin
          reached_min <= 1'b1;
        end
        if (cmd.chk_max && max_enable && (mq > sq || (mq == sq && mfrac))) begin
          exceeded_max <= 1'b1;
        end
      end
    end
  end

  assign stat.has_cand = has_r;
  assign stat.is_last  = last_r;

endmodule
